/* rtl/core/pst_pkg.sv */
// Shared types and constants of the periodic slot timer table.
package pst_pkg;

    // Field widths
    localparam int ACC_W       = 33;
    localparam int PER_W       = 32;
    localparam int LIM_W       = 16;
    localparam int DT_W        = 16;
    localparam int SLOT_W      = 3;
    localparam int MASK_W      = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    // Command codes carried in tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PROG = 1'b1;

    // Stored slot record
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [PER_W-1:0] period;
        logic [LIM_W-1:0] limit;
        logic [LIM_W-1:0] count;
    } t_slot_rec;

    // Result of one slot update
    typedef struct packed {
        logic      wr_en;
        logic      fire;
        logic      active;
        t_slot_rec rec;
    } t_slot_upd;

endpackage

/* rtl/core/periodic_slot_timer_table.sv */
// Top level of the periodic slot timer table: slot memory, scan sequencer, result register.
// Program transfer: a valid slot is written in idle, then the finish state loads the result register.
// Tick transfer: the scan state reads one slot a cycle through the registered memory read into the
//   single update unit, then the finish state loads the result register. Input is taken only in idle.
// The result register lets a new input transfer start while the previous result waits.
// Synchronous active-low reset: all slots inactive, no result pending; slot memory is not cleared.
module periodic_slot_timer_table #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slot [2:0], elapsed [18:3], period [50:19], pass_limit [66:51], zero fill [71:67]
    input  logic [pst_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // command [0]
    input  logic                                i_s_tuser,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // fired_mask [7:0], active_mask [15:8]
    output logic [pst_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    // one spare bit so that NUM_SLOTS itself fits for range compares
    localparam int IW = ((AW > pst_pkg::SLOT_W) ? AW : pst_pkg::SLOT_W) + 1;
    localparam int MW = (NUM_SLOTS > pst_pkg::MASK_W) ? NUM_SLOTS : pst_pkg::MASK_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Input field unpacking
    logic [pst_pkg::SLOT_W-1:0] w_slot;
    logic [pst_pkg::DT_W-1:0]   w_elapsed;
    logic [pst_pkg::PER_W-1:0]  w_period;
    logic [pst_pkg::LIM_W-1:0]  w_limit;
    logic [IW-1:0]              w_slot_ext;
    logic [AW-1:0]              w_slot_addr;
    logic                       w_slot_ok;
    logic                       w_in_xfer;

    assign w_slot      = i_s_tdata[2:0];
    assign w_elapsed   = i_s_tdata[18:3];
    assign w_period    = i_s_tdata[50:19];
    assign w_limit     = i_s_tdata[66:51];
    assign w_slot_ext  = IW'(w_slot);
    assign w_slot_addr = w_slot_ext[AW-1:0];
    assign w_slot_ok   = (w_slot_ext < IW'(NUM_SLOTS));
    assign w_in_xfer   = i_s_tvalid && o_s_tready;

    // Control and datapath registers
    logic [1:0]                  r_state, n_state;
    logic [CW-1:0]               r_rd_idx, n_rd_idx;
    logic                        r_pipe_vld, n_pipe_vld;
    logic [AW-1:0]               r_pipe_idx, n_pipe_idx;
    logic [pst_pkg::DT_W-1:0]    r_dt, n_dt;
    logic [NUM_SLOTS-1:0]        r_active, n_active;
    logic [pst_pkg::MASK_W-1:0]  r_fired, n_fired;
    logic                        r_out_vld, n_out_vld;
    logic [pst_pkg::MASK_W-1:0]  r_out_fired, n_out_fired;
    logic [pst_pkg::MASK_W-1:0]  r_out_active, n_out_active;

    // Slot memory and its ports
    pst_pkg::t_slot_rec r_mem [NUM_SLOTS];
    pst_pkg::t_slot_rec r_rd_data;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    pst_pkg::t_slot_rec w_wdata;
    logic               w_rd_go;
    logic [AW-1:0]      w_raddr;

    // Shared update unit
    pst_pkg::t_slot_upd w_upd;
    logic [IW-1:0]      w_pipe_ext;
    logic [MW-1:0]      w_act_ext;

    assign w_pipe_ext = IW'(r_pipe_idx);
    assign w_act_ext  = MW'(r_active);
    assign w_raddr    = r_rd_idx[AW-1:0];
    assign w_rd_go    = (r_state == S_SCAN) && (r_rd_idx < CW'(NUM_SLOTS));

    pst_slot_alu u_alu (
        .i_rec    (r_rd_data),
        .i_active (r_active[r_pipe_idx]),
        .i_dt     (r_dt),
        .o_upd    (w_upd)
    );

    // Handshake outputs
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_active, r_out_fired};

    // Memory write port: program write or scan write-back
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_slot_addr;
        w_wdata = '{acc: '0, period: w_period, limit: w_limit, count: '0};
        if (r_state == S_IDLE) begin
            w_we = w_in_xfer && (i_s_tuser == pst_pkg::CMD_PROG) && w_slot_ok;
        end else if (r_state == S_SCAN && r_pipe_vld) begin
            w_we    = w_upd.wr_en;
            w_waddr = r_pipe_idx;
            w_wdata = w_upd.rec;
        end
    end

    // Slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_pipe_vld   = 1'b0;
        n_pipe_idx   = r_pipe_idx;
        n_dt         = r_dt;
        n_active     = r_active;
        n_fired      = r_fired;
        n_out_vld    = r_out_vld;
        n_out_fired  = r_out_fired;
        n_out_active = r_out_active;

        // result taken downstream
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_fired = '0;
                    if (i_s_tuser == pst_pkg::CMD_PROG) begin
                        if (w_slot_ok) begin
                            n_active[w_slot_addr] = (w_period != '0);
                        end
                        n_state = S_FINISH;
                    end else begin
                        n_dt     = w_elapsed;
                        n_rd_idx = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue read of the next slot
                if (w_rd_go) begin
                    n_rd_idx   = r_rd_idx + CW'(1);
                    n_pipe_vld = 1'b1;
                    n_pipe_idx = w_raddr;
                end
                // update the slot whose record just came out of memory
                if (r_pipe_vld) begin
                    n_active[r_pipe_idx] = w_upd.active;
                    if (w_upd.fire && (w_pipe_ext < IW'(pst_pkg::MASK_W))) begin
                        n_fired[w_pipe_ext[2:0]] = 1'b1;
                    end
                    if (r_pipe_idx == AW'(NUM_SLOTS - 1)) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld    = 1'b1;
                    n_out_fired  = r_fired;
                    n_out_active = w_act_ext[pst_pkg::MASK_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pipe_vld <= 1'b0;
            r_active   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pipe_vld <= n_pipe_vld;
            r_active   <= n_active;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_pipe_idx   <= n_pipe_idx;
        r_dt         <= n_dt;
        r_fired      <= n_fired;
        r_out_fired  <= n_out_fired;
        r_out_active <= n_out_active;
    end

    // Checks
    a_ready_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("input ready outside idle");

    a_pipe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_vld |-> (IW'(r_pipe_idx) < IW'(NUM_SLOTS)))
        else $error("scan index beyond slot table");

    a_prog_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_s_tuser == pst_pkg::CMD_PROG) && w_slot_ok) |=>
        (r_active[$past(w_slot_addr)] == ($past(w_period) != '0)))
        else $error("program did not set slot active flag");

    a_fired_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((MW'(r_out_fired) & ~MW'({NUM_SLOTS{1'b1}})) == '0))
        else $error("fired bit for slot outside table");

endmodule

/* rtl/core/pst_slot_alu.sv */
// Shared per-slot update unit: accumulate, compare, subtract, pass count.
module pst_slot_alu (
    input  pst_pkg::t_slot_rec           i_rec,
    input  logic                         i_active,
    input  logic [pst_pkg::DT_W-1:0]     i_dt,
    output pst_pkg::t_slot_upd           o_upd
);

    logic                          w_elig;
    logic [pst_pkg::ACC_W:0]       w_sum;
    logic [pst_pkg::ACC_W-1:0]     w_sat;
    logic                          w_ge;
    logic [pst_pkg::LIM_W-1:0]     w_cnt1;
    logic                          w_lim_on;

    // Slot takes part only when running and under its limit
    assign w_lim_on = (i_rec.limit != '0);
    assign w_elig   = i_active && (i_rec.period != '0) &&
                      !(w_lim_on && (i_rec.count >= i_rec.limit));

    // Accumulate with saturation, then compare against the interval
    assign w_sum  = {1'b0, i_rec.acc} + (pst_pkg::ACC_W+1)'(i_dt);
    assign w_sat  = w_sum[pst_pkg::ACC_W] ? '1 : w_sum[pst_pkg::ACC_W-1:0];
    assign w_ge   = (w_sat >= pst_pkg::ACC_W'(i_rec.period));
    assign w_cnt1 = i_rec.count + pst_pkg::LIM_W'(1);

    always_comb begin
        o_upd          = '0;
        o_upd.wr_en    = w_elig;
        o_upd.fire     = w_elig && w_ge;
        o_upd.active   = i_active;
        o_upd.rec      = i_rec;
        if (w_elig) begin
            o_upd.rec.acc = w_ge ? (w_sat - pst_pkg::ACC_W'(i_rec.period)) : w_sat;
            if (w_ge && w_lim_on) begin
                if (w_cnt1 >= i_rec.limit) begin
                    o_upd.rec.count = '0;
                    o_upd.active    = 1'b0;
                end else begin
                    o_upd.rec.count = w_cnt1;
                end
            end
        end
    end

endmodule
